// ===== rtl/vaxr_pkg.sv =====
// ----------------------------------------------------------------------------
// vaxr_pkg
// Shared types and constants for the vector axis rotation pipeline.
// ----------------------------------------------------------------------------
package vaxr_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int ANGLE_WIDTH   = 16;
	localparam int TRIG_FRAC_DEF = 15;

	// CORDIC core: Q30 datapath, 32-bit phase accumulator
	localparam int PHASE_W      = 32;
	localparam int CORDIC_STEPS = 30;
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_GAIN  = 652032874;
	// registers in the trig unit: reduce, steps, negate, round
	localparam int TRIG_LAT     = CORDIC_STEPS + 3;

	typedef enum logic [1:0] {
		OP_YZ = 2'd0,
		OP_XZ = 2'd1,
		OP_XY = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]                     opcode;
		logic signed [COORD_WIDTH-1:0]  in_x;
		logic signed [COORD_WIDTH-1:0]  in_y;
		logic signed [COORD_WIDTH-1:0]  in_z;
		logic [ANGLE_WIDTH-1:0]         angle;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0]  out_x;
		logic signed [COORD_WIDTH-1:0]  out_y;
		logic signed [COORD_WIDTH-1:0]  out_z;
	} res_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [PHASE_W-1:0] atan_step(input int i);
		logic [PHASE_W-1:0] a;
		case (i)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			24: a = 32'd41;
			25: a = 32'd20;
			26: a = 32'd10;
			27: a = 32'd5;
			28: a = 32'd3;
			29: a = 32'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/vaxr_cordic.sv =====
// ----------------------------------------------------------------------------
// vaxr_cordic
// Pipelined rotation-mode CORDIC: binary angle in, cosine and sine out in
// signed Q1.F, one angle per cycle.
// ----------------------------------------------------------------------------
module vaxr_cordic #(
	parameter int TRIG_FRAC_BITS = vaxr_pkg::TRIG_FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [vaxr_pkg::ANGLE_WIDTH-1:0]   angle,
	output logic                               vld,
	output logic signed [TRIG_FRAC_BITS:0]     cosine,
	output logic signed [TRIG_FRAC_BITS:0]     sine
);
	import vaxr_pkg::*;

	localparam int STEPS = CORDIC_STEPS;
	localparam int CW    = CORDIC_W;
	localparam int SH    = 30 - TRIG_FRAC_BITS;
	localparam logic signed [CW-1:0] ONE_L = {{(CW-1){1'b0}}, 1'b1};
	localparam logic signed [CW-1:0] RND   = ONE_L << (SH - 1);
	localparam logic signed [CW-1:0] TONE  = ONE_L << TRIG_FRAC_BITS;
	localparam logic signed [CW-1:0] TMAX  = TONE - ONE_L;
	localparam logic signed [CW-1:0] TMIN  = -TONE;
	localparam logic signed [CW-1:0] GAIN  = CW'(CORDIC_GAIN);

	logic [PHASE_W-1:0] phase;
	logic               flip;

	logic signed [CW-1:0] x_s    [0:STEPS];
	logic signed [CW-1:0] y_s    [0:STEPS];
	logic signed [CW-1:0] z_s    [0:STEPS];
	logic                 flip_s [0:STEPS];
	logic                 vld_s  [0:STEPS];

	logic signed [CW-1:0] xn_s, yn_s;
	logic                 vn_s;
	logic signed [CW-1:0] xr, yr;

	// second and third quadrant: turn by a half turn, negate at the end
	always_comb begin
		phase = {angle, {(PHASE_W-ANGLE_WIDTH){1'b0}}};
		flip  = phase[PHASE_W-1] ^ phase[PHASE_W-2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= CW'(signed'({phase[PHASE_W-1] ^ flip, phase[PHASE_W-2:0]}));
		flip_s[0] <= flip;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [CW-1:0] dx, dy, at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = CW'(atan_step(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - at;
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + at;
			end
		end
	end

	// undo quadrant fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vn_s <= 1'b0;
			vld  <= 1'b0;
		end else begin
			vn_s <= vld_s[STEPS];
			vld  <= vn_s;
		end
	end

	always_ff @(posedge clk) begin
		xn_s <= flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		yn_s <= flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	end

	// round half up from Q30, clamp to [-1, 1 - lsb]
	always_comb begin
		xr = (xn_s + RND) >>> SH;
		yr = (yn_s + RND) >>> SH;
	end

	always_ff @(posedge clk) begin
		if (xr > TMAX)      cosine <= TMAX[TRIG_FRAC_BITS:0];
		else if (xr < TMIN) cosine <= TMIN[TRIG_FRAC_BITS:0];
		else                cosine <= xr[TRIG_FRAC_BITS:0];
		if (yr > TMAX)      sine <= TMAX[TRIG_FRAC_BITS:0];
		else if (yr < TMIN) sine <= TMIN[TRIG_FRAC_BITS:0];
		else                sine <= yr[TRIG_FRAC_BITS:0];
	end

endmodule

// ===== rtl/vector_axis_rotation.sv =====
// ----------------------------------------------------------------------------
// vector_axis_rotation
// Rotates a Q16.16 point about the x, y or z axis by a binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; a transfer happens on every
//   rising edge with start high and busy low. busy is always low: the block
//   is a free-running pipeline and takes one point per clock.
//   Result channel: done pulses for one cycle with res holding the rotated
//   point. There is no back-pressure; results must be taken when shown.
//   Pipeline: a command passes the CORDIC pipe, then the multiply, sum and
//   saturate/output registers before done goes high with its result.
//   Throughput: one point per cycle, set by the fully pipelined CORDIC
//   (one micro-rotation per stage) and four parallel multipliers.
//   Reset: arst_n clears all valid bits; in-flight points are dropped and
//   done stays low until new commands come out the far end.
//   opcode 0 rotates y-z, 1 x-z, 2 x-y; the axis coordinate passes through,
//   and opcode 3 passes the whole point through.
//   Results saturate to the signed 32-bit coordinate range.
// ----------------------------------------------------------------------------
module vector_axis_rotation #(
	parameter int TRIG_FRAC_BITS = vaxr_pkg::TRIG_FRAC_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  vaxr_pkg::cmd_t  cmd,
	output logic            done,
	output vaxr_pkg::res_t  res
);
	import vaxr_pkg::*;

	localparam int TF  = TRIG_FRAC_BITS;
	// product and sum widths
	localparam int PW  = COORD_WIDTH + TF + 1;
	localparam int SW  = PW + 1;
	localparam int LAT = TRIG_LAT + 3;
	localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (TF - 1);
	localparam logic signed [SW-1:0] CMAX = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [SW-1:0] CMIN = -CMAX - {{(SW-1){1'b0}}, 1'b1};

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] q;
		q = v >>> TF;
		if (q > CMAX)      return CMAX[COORD_WIDTH-1:0];
		else if (q < CMIN) return CMIN[COORD_WIDTH-1:0];
		else               return q[COORD_WIDTH-1:0];
	endfunction

	logic accept;

	// trig unit
	logic                  t_vld;
	logic signed [TF:0]    t_cos, t_sin;

	// command line riding alongside the CORDIC
	cmd_t cmd_line_q [0:TRIG_LAT-1];
	cmd_t cmd_a;

	// plane selection: u' = u*c - v*s, v' = u*s + v*c, w passes
	logic signed [COORD_WIDTH-1:0] u, v, w;

	// multiply stage
	logic                          vld_s1;
	logic [1:0]                    op_s1;
	logic signed [COORD_WIDTH-1:0] u_s1, v_s1, w_s1;
	logic signed [PW-1:0]          uc_s1, vs_s1, us_s1, vc_s1;

	// sum stage
	logic                          vld_s2;
	logic [1:0]                    op_s2;
	logic signed [COORD_WIDTH-1:0] u_s2, v_s2, w_s2;
	logic signed [SW-1:0]          su_s2, sv_s2;

	logic signed [COORD_WIDTH-1:0] uo, vo;
	res_t                          res_d;
	logic                          done_q;
	res_t                          res_q;

	// pipeline never holds off a command
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	vaxr_cordic #(
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (cmd.angle),
		.vld    (t_vld),
		.cosine (t_cos),
		.sine   (t_sin)
	);

	always_ff @(posedge clk) begin
		cmd_line_q[0] <= cmd;
		for (int k = 1; k < TRIG_LAT; k++) begin
			cmd_line_q[k] <= cmd_line_q[k-1];
		end
	end

	assign cmd_a = cmd_line_q[TRIG_LAT-1];

	// x-z plane uses u=z, v=x so that one rotation form covers all planes
	always_comb begin
		unique case (cmd_a.opcode)
			OP_YZ: begin
				u = cmd_a.in_y; v = cmd_a.in_z; w = cmd_a.in_x;
			end
			OP_XZ: begin
				u = cmd_a.in_z; v = cmd_a.in_x; w = cmd_a.in_y;
			end
			OP_XY: begin
				u = cmd_a.in_x; v = cmd_a.in_y; w = cmd_a.in_z;
			end
			default: begin
				u = cmd_a.in_x; v = cmd_a.in_y; w = cmd_a.in_z;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= t_vld;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cmd_a.opcode;
		u_s1  <= u;
		v_s1  <= v;
		w_s1  <= w;
		uc_s1 <= PW'(u) * PW'(t_cos);
		vs_s1 <= PW'(v) * PW'(t_sin);
		us_s1 <= PW'(u) * PW'(t_sin);
		vc_s1 <= PW'(v) * PW'(t_cos);
	end

	// exact sum plus half lsb; the shift happens in the saturate stage
	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		u_s2  <= u_s1;
		v_s2  <= v_s1;
		w_s2  <= w_s1;
		su_s2 <= SW'(uc_s1) - SW'(vs_s1) + HALF;
		sv_s2 <= SW'(us_s1) + SW'(vc_s1) + HALF;
	end

	always_comb begin
		uo = sat(su_s2);
		vo = sat(sv_s2);
		unique case (op_s2)
			OP_YZ: begin
				res_d.out_x = w_s2; res_d.out_y = uo; res_d.out_z = vo;
			end
			OP_XZ: begin
				res_d.out_x = vo; res_d.out_y = w_s2; res_d.out_z = uo;
			end
			OP_XY: begin
				res_d.out_x = uo; res_d.out_y = vo; res_d.out_z = w_s2;
			end
			default: begin
				res_d.out_x = u_s2; res_d.out_y = v_s2; res_d.out_z = w_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

	// every transfer yields exactly one result
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("command transfer without matching result");

	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching command transfer");

	// axis coordinate must come through untouched
	a_xy_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_XY) |-> ##LAT (res.out_z == $past(cmd.in_z, LAT)))
		else $error("z changed in x-y rotation");

	a_yz_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_YZ) |-> ##LAT (res.out_x == $past(cmd.in_x, LAT)))
		else $error("x changed in y-z rotation");

	a_xz_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_XZ) |-> ##LAT (res.out_y == $past(cmd.in_y, LAT)))
		else $error("y changed in x-z rotation");

endmodule
